// ----- rtl/accept_encoding_gzip_stripper_unit_defines.svh -----
// ----------------------------------------------------------------------------
// accept-encoding gzip stripper: assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef ACCEPT_ENCODING_GZIP_STRIPPER_UNIT_DEFINES_SVH
`define ACCEPT_ENCODING_GZIP_STRIPPER_UNIT_DEFINES_SVH

// property checked outside reset
`define AEGS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define AEGS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/aegs_pkg.sv -----
// ----------------------------------------------------------------------------
// aegs_pkg
// types, constants and match tables of the gzip stripper
// ----------------------------------------------------------------------------
package aegs_pkg;

    localparam int HOLD_DEPTH = 6;
    localparam int WIN_LEN    = HOLD_DEPTH + 1;
    localparam int HEADER_LEN = 17;
    localparam int TOKEN_LEN  = 4;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] REMOVED_SHORT = 3'd5;
    localparam logic [2:0] REMOVED_LONG  = 3'd6;

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE = 1'b0;

    typedef enum logic [1:0] {
        PH_SEEK_HEADER = 2'd0,
        PH_SEEK_TOKEN  = 2'd1,
        PH_DONE        = 2'd2,
        PH_DECIDE      = 2'd3
    } t_phase;

    typedef logic [7:0]         t_byte;
    typedef logic [2:0]         t_fill;
    typedef logic [WIN_LEN-1:0] t_mask;

    // one queue entry: the byte window and which of its bytes go out
    typedef struct packed {
        t_byte [WIN_LEN-1:0] win;
        t_mask               mask;
        logic                last;
        logic [2:0]          removed;
    } t_entry;

    // "Accept-Encoding: "
    function automatic t_byte header_char(input logic [4:0] pos);
        t_byte c;
        case (pos)
            5'd0:    c = 8'h41;
            5'd1:    c = 8'h63;
            5'd2:    c = 8'h63;
            5'd3:    c = 8'h65;
            5'd4:    c = 8'h70;
            5'd5:    c = 8'h74;
            5'd6:    c = 8'h2D;
            5'd7:    c = 8'h45;
            5'd8:    c = 8'h6E;
            5'd9:    c = 8'h63;
            5'd10:   c = 8'h6F;
            5'd11:   c = 8'h64;
            5'd12:   c = 8'h69;
            5'd13:   c = 8'h6E;
            5'd14:   c = 8'h67;
            5'd15:   c = 8'h3A;
            5'd16:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "gzip"
    function automatic t_byte token_char(input logic [1:0] pos);
        t_byte c;
        case (pos)
            2'd0:    c = 8'h67;
            2'd1:    c = 8'h7A;
            2'd2:    c = 8'h69;
            2'd3:    c = 8'h70;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/accept_encoding_gzip_stripper_unit.sv -----
// path: a byte taken passes the queue, the output side's window register and the output register, and
//   waits longer in the hold line for the gzip decision or behind earlier bytes
// throughput: one input word per cycle; the output side sends one word per cycle when not stalled,
//   so an input that releases several words (flush at packet end) holds the input only once the queue fills
// reset: synchronous, active low; search state, queue and output valid clear, enable returns to 1
// ----------------------------------------------------------------------------
// accept_encoding_gzip_stripper_unit
// strips the gzip token from a packet's accept-encoding header
// ----------------------------------------------------------------------------
module accept_encoding_gzip_stripper_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    // output word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [2:0]  o_removed_count,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aegs_pkg::*;

    // enable register, single entry, selected by paddr[2] low (byte addresses 0 to 3)
    logic   r_enable;
    logic   cfg_wr;

    // front to queue, queue to back
    t_entry front_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENABLE);
    assign prdata = (paddr[2] == REG_ENABLE) ? {31'b0, r_enable} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (cfg_wr) begin
            r_enable <= pwdata[0];
        end
    end

    // front: matches "Accept-Encoding: " then "gzip" on that line, holds up to six
    // words in a delay line and, per accepted word, posts the window of held words
    // plus the new one along with a mask of the words to send; the mask carries the
    // whole edit (which of the space, gzip and a comma on either side are dropped)
    aegs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (r_enable),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_packet(i_end_of_packet),
        .i_full         (q_full),
        .o_push         (push),
        .o_entry        (front_entry)
    );

    // queue: lets the search take a word each cycle, until it fills, while the output side is
    // still draining a multi-word flush or is stalled downstream
    aegs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(front_entry),
        .o_full (q_full),
        .i_pop  (pop),
        .o_entry(head_entry),
        .o_empty(q_empty)
    );

    // back: one word a cycle, unless stalled downstream, from the lowest set mask bit; the next window is
    // loaded as the last word of the current one goes out, so there is no gap
    aegs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (head_entry),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_removed_count(o_removed_count)
    );

endmodule

// ----- rtl/aegs_front.sv -----
// ----------------------------------------------------------------------------
// aegs_front
// header and token search, hold line, picks the bytes each input releases
// ----------------------------------------------------------------------------
module aegs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_enable,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_packet,
    input  logic             i_full,
    output logic             o_push,
    output aegs_pkg::t_entry o_entry
);
    import aegs_pkg::*;

    t_byte      r_hold [HOLD_DEPTH];
    t_byte      n_hold [HOLD_DEPTH];
    t_fill      r_fill, n_fill;
    logic [4:0] r_hdr_pos, n_hdr_pos;
    logic [1:0] r_tok_pos, n_tok_pos;
    t_phase     r_phase, n_phase;
    logic       r_cr, n_cr;
    logic [2:0] r_removed, n_removed;

    logic                accept;
    t_byte [WIN_LEN-1:0] win;
    t_mask               full_mask;
    t_mask               base_mask;
    t_mask               mask;
    logic [2:0]          step_removed;
    logic                fill_full;
    logic                fill_six_after;
    t_byte               hold0_after;
    logic                hdr_hit, hdr_done;
    logic [4:0]          hdr_next;
    logic                tok_hit, tok_done;
    logic [1:0]          tok_next;
    logic                crlf;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;

    // window: held bytes then the incoming one
    always_comb begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            win[i] = (t_fill'(i) < r_fill) ? r_hold[i] : i_data_byte;
        end
        win[HOLD_DEPTH] = i_data_byte;
        for (int i = 0; i < WIN_LEN; i++) begin
            full_mask[i] = (t_fill'(i) <= r_fill);
        end
    end

    assign fill_full      = (r_fill == t_fill'(HOLD_DEPTH));
    assign fill_six_after = fill_full || (r_fill == t_fill'(HOLD_DEPTH - 1));
    assign hold0_after    = fill_full ? win[1] : win[0];
    assign base_mask      = fill_full ? t_mask'(1) : '0;

    assign hdr_hit  = (i_data_byte == header_char(r_hdr_pos));
    assign hdr_next = hdr_hit ? r_hdr_pos + 5'd1
                              : {4'b0, i_data_byte == header_char(5'd0)};
    assign hdr_done = hdr_hit && (r_hdr_pos == 5'(HEADER_LEN - 1));

    assign tok_hit  = (i_data_byte == token_char(r_tok_pos));
    assign tok_next = tok_hit ? r_tok_pos + 2'd1
                              : {1'b0, i_data_byte == token_char(2'd0)};
    assign tok_done = tok_hit && (r_tok_pos == 2'(TOKEN_LEN - 1));

    assign crlf = r_cr && (i_data_byte == CH_LF);

    // next state
    always_comb begin
        n_hold    = r_hold;
        n_fill    = r_fill;
        n_hdr_pos = r_hdr_pos;
        n_tok_pos = r_tok_pos;
        n_phase   = r_phase;
        n_cr      = r_cr;
        n_removed = r_removed;
        if (accept) begin
            if (!i_enable) begin
                n_phase = PH_DONE;
                n_fill  = '0;
            end else begin
                case (r_phase)
                    PH_DONE: begin
                        n_fill = '0;
                    end
                    PH_DECIDE: begin
                        n_phase = PH_DONE;
                        n_fill  = '0;
                    end
                    PH_SEEK_HEADER, PH_SEEK_TOKEN: begin
                        // push into the hold line, shift out the oldest when full
                        if (fill_full) begin
                            for (int i = 0; i < HOLD_DEPTH; i++) begin
                                n_hold[i] = win[i+1];
                            end
                        end else begin
                            for (int i = 0; i < HOLD_DEPTH; i++) begin
                                if (t_fill'(i) == r_fill) begin
                                    n_hold[i] = i_data_byte;
                                end
                            end
                            n_fill = r_fill + t_fill'(1);
                        end
                        if (r_phase == PH_SEEK_HEADER) begin
                            n_hdr_pos = hdr_done ? 5'd0 : hdr_next;
                            if (hdr_done) begin
                                n_tok_pos = '0;
                                n_cr      = 1'b0;
                                n_phase   = PH_SEEK_TOKEN;
                            end
                        end else begin
                            n_cr      = (i_data_byte == CH_CR);
                            n_tok_pos = tok_done ? 2'd0 : tok_next;
                            if (tok_done) begin
                                n_phase = PH_DECIDE;
                            end else if (crlf) begin
                                n_phase = PH_DONE;
                                n_fill  = '0;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
            n_removed = step_removed;
            if (i_end_of_packet) begin
                n_fill    = '0;
                n_hdr_pos = '0;
                n_tok_pos = '0;
                n_phase   = PH_SEEK_HEADER;
                n_cr      = 1'b0;
                n_removed = '0;
            end
        end
    end

    // released bytes and removed count
    always_comb begin
        mask         = full_mask;
        step_removed = r_removed;
        if (i_enable) begin
            case (r_phase)
                PH_DONE: begin
                    mask = full_mask;
                end
                PH_DECIDE: begin
                    if (!fill_full) begin
                        mask = full_mask;
                    end else if (i_data_byte == CH_COMMA) begin
                        mask         = t_mask'(1);
                        step_removed = REMOVED_LONG;
                    end else if (win[0] == CH_COMMA) begin
                        mask         = t_mask'(1) << HOLD_DEPTH;
                        step_removed = REMOVED_LONG;
                    end else begin
                        mask         = t_mask'(1) | (t_mask'(1) << HOLD_DEPTH);
                        step_removed = REMOVED_SHORT;
                    end
                end
                PH_SEEK_HEADER: begin
                    mask = i_end_of_packet ? full_mask : base_mask;
                end
                PH_SEEK_TOKEN: begin
                    if (tok_done && i_end_of_packet) begin
                        // token on the final byte: decide without a next byte
                        if (!fill_six_after) begin
                            mask = full_mask;
                        end else if (hold0_after == CH_COMMA) begin
                            mask         = base_mask;
                            step_removed = REMOVED_LONG;
                        end else begin
                            mask         = base_mask | (fill_full ? t_mask'(2) : t_mask'(1));
                            step_removed = REMOVED_SHORT;
                        end
                    end else if (tok_done) begin
                        mask = base_mask;
                    end else if (crlf || i_end_of_packet) begin
                        mask = full_mask;
                    end else begin
                        mask = base_mask;
                    end
                end
                default: begin
                    mask = full_mask;
                end
            endcase
        end
    end

    assign o_push          = accept && (mask != '0);
    assign o_entry.win     = win;
    assign o_entry.mask    = mask;
    assign o_entry.last    = i_end_of_packet;
    assign o_entry.removed = step_removed;

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_hdr_pos <= '0;
            r_tok_pos <= '0;
            r_phase   <= PH_SEEK_HEADER;
            r_cr      <= 1'b0;
            r_removed <= '0;
        end else begin
            r_fill    <= n_fill;
            r_hdr_pos <= n_hdr_pos;
            r_tok_pos <= n_tok_pos;
            r_phase   <= n_phase;
            r_cr      <= n_cr;
            r_removed <= n_removed;
        end
    end

endmodule

// ----- rtl/aegs_queue.sv -----
// ----------------------------------------------------------------------------
// aegs_queue
// short fifo of byte windows between search and output sides
// ----------------------------------------------------------------------------
module aegs_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  aegs_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output aegs_pkg::t_entry o_entry,
    output logic             o_empty
);
    import aegs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/aegs_back.sv -----
// ----------------------------------------------------------------------------
// aegs_back
// walks each window's byte mask and drives the output register
// ----------------------------------------------------------------------------
module aegs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  aegs_pkg::t_entry i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic [2:0]       o_removed_count
);
    import aegs_pkg::*;

    t_byte [WIN_LEN-1:0] r_win;
    t_mask               r_mask;
    logic                r_last;
    logic [2:0]          r_removed;
    logic                r_out_valid;
    t_byte               r_out_byte;
    logic                r_out_last;
    logic [2:0]          r_out_removed;

    logic  out_free;
    logic  emit;
    logic  cur_done;
    logic  fin;
    t_mask sel;
    t_mask rest;
    t_byte sel_byte;

    assign out_free = !r_out_valid || !i_out_stall;
    assign sel      = r_mask & (~r_mask + t_mask'(1));
    assign rest     = r_mask & ~sel;
    assign emit     = out_free && (r_mask != '0);
    assign fin      = (rest == '0);
    assign cur_done = (r_mask == '0) || (emit && fin);
    assign o_pop    = cur_done && !i_empty;

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < WIN_LEN; i++) begin
            sel_byte = sel_byte | (sel[i] ? r_win[i] : t_byte'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_win     <= i_entry.win;
            r_last    <= i_entry.last;
            r_removed <= i_entry.removed;
        end
        if (emit) begin
            r_out_byte    <= sel_byte;
            r_out_last    <= r_last && fin;
            r_out_removed <= (r_last && fin) ? r_removed : 3'd0;
        end
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mask <= i_entry.mask;
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_out_last      = r_out_last;
    assign o_removed_count = r_out_removed;

endmodule

// ----- rtl/aegs_checker.sv -----
// ----------------------------------------------------------------------------
// aegs_checker
// port-level checks on the gzip stripper, bound to the top level
// ----------------------------------------------------------------------------
`include "accept_encoding_gzip_stripper_unit_defines.svh"

module aegs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_out_last,
    input logic [2:0]  o_removed_count
);

    // a stalled word holds
    `AEGS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_out_last) && $stable(o_removed_count), "stalled output word changed")

    // removed count only rides on the last word of a packet
    `AEGS_ASSERT(a_removed_on_last, i_clk, i_rst_n, o_out_valid && !o_out_last |-> o_removed_count == 3'd0, "removed count outside packet end")

    // at most six bytes are ever removed
    `AEGS_ASSERT(a_removed_range, i_clk, i_rst_n, o_out_valid |-> o_removed_count != 3'd7, "removed count out of range")

    // reset empties the output register
    `AEGS_ASSERT_ALWAYS(a_reset_clears, i_clk, !$past(i_rst_n) |-> !o_out_valid, "output valid after reset")

endmodule

bind accept_encoding_gzip_stripper_unit aegs_checker u_aegs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_byte     (o_out_byte),
    .o_out_last     (o_out_last),
    .o_removed_count(o_removed_count)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for accept_encoding_gzip_stripper_unit
// drives byte words with random gaps and stalls, predicts the rewritten
// stream with an in-bench model of the gzip stripper and checks every word
// ----------------------------------------------------------------------------
module testbench;

    import aegs_pkg::*;

    // run length and timing
    localparam int RANDOM_ITEMS  = 260;
    localparam int SETTLE_CYCLES = 24;
    localparam int PRESS_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 400000;

    // register indexes
    localparam int REG_UNMAPPED = 1;

    localparam string HDR_TEXT = "Accept-Encoding: ";
    localparam string TOK_TEXT = "gzip";

    // one word of the rewritten stream
    typedef struct packed {
        t_byte      data;
        logic       last;
        logic [2:0] removed;
    } t_out_word;

    typedef enum logic [1:0] {
        CFG_NONE,
        CFG_ENABLE,
        CFG_UNMAPPED
    } t_cfg_op;

    // one row of the directed table: optional register write, then a word
    typedef struct packed {
        t_cfg_op   op;
        logic      value;
        t_byte     data;
        logic      eop;
        logic      typed;
        t_out_word want;
    } t_row;

    typedef enum int {
        PK_NOISE,
        PK_COMMA_AFTER,
        PK_COMMA_BEFORE,
        PK_BARE,
        PK_GZIP_LAST,
        PK_LINE_ENDS,
        PK_NO_CRLF,
        PK_BROKEN,
        PK_DISABLE_MID,
        PK_PASS,
        PK_COUNT
    } t_pkt_kind;

    localparam t_out_word NO_WANT = '0;

    // typed rows only where the answer is plain: single bytes, pass-through
    localparam int N_ROWS = 23;
    localparam t_row DIRECTED [N_ROWS] = '{
        // straight after reset: one-byte packets at the byte extremes
        '{CFG_NONE,     1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 3'd0}},
        '{CFG_NONE,     1'b0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 3'd0}},
        // two-byte packet, held and flushed at packet end
        '{CFG_NONE,     1'b0, 8'h41, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h78, 1'b1, 1'b0, NO_WANT},
        // crlf outside any header
        '{CFG_NONE,     1'b0, 8'h0D, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h0A, 1'b1, 1'b0, NO_WANT},
        // write to an unmapped register leaves enable alone
        '{CFG_UNMAPPED, 1'b0, 8'h67, 1'b1, 1'b1, '{8'h67, 1'b1, 3'd0}},
        // disabled: every byte passes at once
        '{CFG_ENABLE,   1'b0, 8'h55, 1'b0, 1'b1, '{8'h55, 1'b0, 3'd0}},
        '{CFG_NONE,     1'b0, 8'hAA, 1'b1, 1'b1, '{8'hAA, 1'b1, 3'd0}},
        '{CFG_NONE,     1'b0, 8'h67, 1'b0, 1'b1, '{8'h67, 1'b0, 3'd0}},
        '{CFG_NONE,     1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 3'd0}},
        // enabled again: a false start of the header
        '{CFG_ENABLE,   1'b1, 8'h41, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h63, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h63, 1'b1, 1'b0, NO_WANT},
        // fill the hold line past its depth
        '{CFG_NONE,     1'b0, 8'h80, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h7F, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h01, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'hFE, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h2C, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h20, 1'b0, 1'b0, NO_WANT},
        '{CFG_NONE,     1'b0, 8'h10, 1'b0, 1'b0, NO_WANT},
        // disabled mid-packet: held bytes go out ahead of this one
        '{CFG_ENABLE,   1'b0, 8'h33, 1'b0, 1'b0, NO_WANT},
        // re-enabled before packet end: the packet stays pass-through
        '{CFG_ENABLE,   1'b1, 8'h44, 1'b1, 1'b1, '{8'h44, 1'b1, 3'd0}}
    };

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_packet;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic [2:0]  o_removed_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    accept_encoding_gzip_stripper_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_removed_count (o_removed_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // stripper model: own copy of the search state and of enable
    // ------------------------------------------------------------------------
    t_byte      held [HOLD_DEPTH];
    int         held_fill;
    int         hdr_pos;
    int         tok_pos;
    t_phase     phase;
    logic       cr_seen;
    logic [2:0] removed_tally;
    logic       cfg_enable;
    t_out_word  step_words[$];

    // words still owed by the block, oldest first
    t_out_word  awaited_words[$];
    int         mismatches;

    // payload side-band for typed directed rows, held with the payload
    logic       row_typed;
    t_out_word  row_want;

    function automatic void emit_byte(t_byte b);
        t_out_word w;
        w.data    = b;
        w.last    = 1'b0;
        w.removed = 3'd0;
        step_words.push_back(w);
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_fill; i++)
            emit_byte(held[i]);
        held_fill = 0;
    endfunction

    // shift into the delay line; the oldest byte drops out once it is full
    function automatic void hold_byte(t_byte b);
        if (held_fill >= HOLD_DEPTH) begin
            emit_byte(held[0]);
            for (int i = 0; i < HOLD_DEPTH - 1; i++)
                held[i] = held[i + 1];
            held_fill = HOLD_DEPTH - 1;
        end
        held[held_fill] = b;
        held_fill++;
    endfunction

    // line holds: two bytes before gzip, then gzip itself
    function automatic void decide_edit(logic have_next, t_byte next);
        if (held_fill != HOLD_DEPTH) begin
            flush_held();
            if (have_next)
                emit_byte(next);
        end else if (have_next && next == CH_COMMA) begin
            // comma after gzip: space, gzip and comma go
            emit_byte(held[0]);
            removed_tally = REMOVED_LONG;
        end else if (held[0] == CH_COMMA) begin
            // comma two bytes before gzip: comma, space and gzip go
            if (have_next)
                emit_byte(next);
            removed_tally = REMOVED_LONG;
        end else begin
            emit_byte(held[0]);
            if (have_next)
                emit_byte(next);
            removed_tally = REMOVED_SHORT;
        end
        held_fill = 0;
        phase     = PH_DONE;
    endfunction

    function automatic void start_packet();
        held_fill     = 0;
        hdr_pos       = 0;
        tok_pos       = 0;
        phase         = PH_SEEK_HEADER;
        cr_seen       = 1'b0;
        removed_tally = 3'd0;
    endfunction

    // words caused by one accepted input word, left in step_words
    function automatic void strip_predict(t_byte b, logic eop);
        logic was_cr;
        int   n;
        step_words.delete();
        if (!cfg_enable) begin
            flush_held();
            emit_byte(b);
            phase = PH_DONE;
        end else begin
            case (phase)
                PH_DONE: begin
                    emit_byte(b);
                end
                PH_DECIDE: begin
                    decide_edit(1'b1, b);
                end
                PH_SEEK_HEADER: begin
                    hold_byte(b);
                    if (hdr_pos < HEADER_LEN && b == HDR_TEXT[hdr_pos])
                        hdr_pos++;
                    else
                        hdr_pos = (b == HDR_TEXT[0]) ? 1 : 0;
                    if (hdr_pos >= HEADER_LEN) begin
                        hdr_pos = 0;
                        tok_pos = 0;
                        cr_seen = 1'b0;
                        phase   = PH_SEEK_TOKEN;
                    end
                end
                default: begin
                    was_cr = cr_seen;
                    hold_byte(b);
                    cr_seen = (b == CH_CR);
                    if (tok_pos < TOKEN_LEN && b == TOK_TEXT[tok_pos])
                        tok_pos++;
                    else
                        tok_pos = (b == TOK_TEXT[0]) ? 1 : 0;
                    if (tok_pos >= TOKEN_LEN) begin
                        tok_pos = 0;
                        phase   = PH_DECIDE;
                    end else if (was_cr && b == CH_LF) begin
                        // line ended before any gzip
                        flush_held();
                        phase = PH_DONE;
                    end
                end
            endcase
        end
        if (eop) begin
            if (phase == PH_DECIDE)
                decide_edit(1'b0, 8'h00);
            else
                flush_held();
            n = step_words.size();
            if (n > 0) begin
                step_words[n - 1].last    = 1'b1;
                step_words[n - 1].removed = removed_tally;
            end
            start_packet();
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted input word, check every output word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : word_monitor
        t_out_word got;
        t_out_word want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            strip_predict(i_data_byte, i_end_of_packet);
            if (row_typed)
                awaited_words.push_back(row_want);
            else
                foreach (step_words[k])
                    awaited_words.push_back(step_words[k]);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.data    = o_out_byte;
            got.last    = o_out_last;
            got.removed = o_removed_count;
            if (awaited_words.size() == 0) begin
                $display("%0t unexpected word: expected none, actual byte %02h last %0b removed %0d",
                         $time, got.data, got.last, got.removed);
                mismatches++;
            end else begin
                want = awaited_words.pop_front();
                if (got.data !== want.data) begin
                    $display("%0t out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, got.data);
                    mismatches++;
                end
                if (got.last !== want.last) begin
                    $display("%0t out_last mismatch: expected %0b, actual %0b",
                             $time, want.last, got.last);
                    mismatches++;
                end
                if (got.removed !== want.removed) begin
                    $display("%0t removed_count mismatch: expected %0d, actual %0d",
                             $time, want.removed, got.removed);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    int cycles;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall per word, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    logic press_request;
    logic send_calm;

    initial begin : receiver
        int   stall_for;
        int   calm_words;
        logic press_done;
        i_out_stall = 1'b0;
        calm_words  = 0;
        press_done  = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (press_request && !press_done) begin
                // long hold-off so the block fills and stalls its input
                press_done = 1'b1;
                stall_for  = PRESS_CYCLES;
            end else if (calm_words > 0) begin
                calm_words--;
                stall_for = 0;
            end else begin
                if ($urandom_range(0, 7) == 0)
                    calm_words = $urandom_range(10, 30);
                stall_for = $urandom_range(0, 9);
            end
            if (stall_for > 0) begin
                i_out_stall = 1'b1;
                repeat (stall_for) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // sender side helpers; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------------

    // offer one word after a random gap and wait until it is taken
    task automatic send_word(input t_byte b, input logic eop, input logic typed,
                             input t_out_word want);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_byte     = b;
        i_end_of_packet = eop;
        row_typed       = typed;
        row_want        = want;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // wait for every owed word, then for anything still inside the block
    task automatic settle();
        i_in_valid = 1'b0;
        while (awaited_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write: setup then access, only with the block idle
    task automatic cfg_write(input int idx, input logic [31:0] value);
        settle();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 3'(idx * 4);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == int'(REG_ENABLE))
            cfg_enable = value[0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // enable with random upper bits, which the block must ignore
    task automatic set_enable(input logic on);
        cfg_write(int'(REG_ENABLE), ($urandom & 32'hFFFF_FFFE) | {31'd0, on});
    endtask

    // ------------------------------------------------------------------------
    // packet builder for the random part
    // ------------------------------------------------------------------------
    t_byte pkt_bytes[$];
    int    pkt_disable_at;
    int    pkt_enable_at;

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            pkt_bytes.push_back(t_byte'(s[i]));
    endfunction

    // random bytes, with header starts and carriage returns mixed in
    function automatic void add_noise(int n);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0:       pkt_bytes.push_back(t_byte'(HDR_TEXT[0]));
                1:       pkt_bytes.push_back(CH_CR);
                default: pkt_bytes.push_back(t_byte'($urandom));
            endcase
        end
    endfunction

    // tokens ahead of gzip: commas, near misses and a lone cr
    function automatic string pick_lead();
        string s;
        case ($urandom_range(0, 5))
            0:       s = "";
            1:       s = "br, ";
            2:       s = "deflate,";
            3:       s = "gzi ";
            4:       s = "gzgz ";
            default: s = "q\r ";
        endcase
        return s;
    endfunction

    function automatic void build_packet(t_pkt_kind kind);
        int idx;
        pkt_bytes.delete();
        pkt_disable_at = -1;
        pkt_enable_at  = -1;
        if (kind == PK_NOISE) begin
            add_noise($urandom_range(1, 16));
            return;
        end
        add_noise($urandom_range(0, 3));
        if ($urandom_range(0, 1))
            add_text("Host: x\r\n");
        add_text(HDR_TEXT);
        case (kind)
            PK_COMMA_AFTER, PK_DISABLE_MID: begin
                add_text(pick_lead());
                add_text("gzip, deflate\r\n");
            end
            PK_COMMA_BEFORE: begin
                if ($urandom_range(0, 1))
                    add_text("br, ");
                else
                    add_text("deflate,");
                add_text("gzip");
                if ($urandom_range(0, 1))
                    add_text("\r\n");
                else
                    add_text(";q=1\r\n");
            end
            PK_BARE: begin
                if ($urandom_range(0, 1))
                    add_text("br ");
                add_text("gzip");
                if ($urandom_range(0, 1))
                    add_text(" br\r\n");
                else
                    add_text("\r\n");
            end
            PK_GZIP_LAST: begin
                // gzip is the final byte: nothing follows to decide on
                if ($urandom_range(0, 1))
                    add_text("br, ");
                add_text("gzip");
                return;
            end
            PK_LINE_ENDS: begin
                add_text("deflate\r\nX: gzip\r\n");
            end
            PK_NO_CRLF: begin
                // header line cut off by packet end
                add_text(pick_lead());
                add_text("gzip");
                if ($urandom_range(0, 1))
                    add_text(";q");
                else
                    add_text(",br");
                return;
            end
            PK_BROKEN: begin
                idx = pkt_bytes.size() - $urandom_range(1, HEADER_LEN);
                pkt_bytes[idx] = pkt_bytes[idx] ^ 8'h20;
                add_text("gzip, br\r\n");
            end
            default: begin
                add_text("gzip, br\r\n");
            end
        endcase
        add_noise($urandom_range(0, 5));
        if (kind == PK_DISABLE_MID) begin
            pkt_disable_at = $urandom_range(1, pkt_bytes.size() - 1);
            if ($urandom_range(0, 1))
                pkt_enable_at = $urandom_range(pkt_disable_at + 1, pkt_bytes.size());
        end
    endfunction

    task automatic send_packet();
        int last_idx;
        last_idx = pkt_bytes.size() - 1;
        for (int i = 0; i <= last_idx; i++) begin
            if (i == pkt_disable_at)
                set_enable(1'b0);
            if (i == pkt_enable_at)
                set_enable(1'b1);
            send_word(pkt_bytes[i], i == last_idx, 1'b0, NO_WANT);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int        n_rand;
        int        pkt_no;
        t_pkt_kind kind;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = 8'h00;
        i_end_of_packet = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'd0;
        row_typed       = 1'b0;
        row_want        = NO_WANT;
        press_request   = 1'b0;
        send_calm       = 1'b0;
        cfg_enable      = 1'b1;
        start_packet();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            case (DIRECTED[r].op)
                CFG_ENABLE:   set_enable(DIRECTED[r].value);
                CFG_UNMAPPED: cfg_write(REG_UNMAPPED, {31'd0, DIRECTED[r].value});
                default:      ;
            endcase
            send_word(DIRECTED[r].data, DIRECTED[r].eop, DIRECTED[r].typed,
                      DIRECTED[r].want);
        end

        // back pressure: a long noise packet offered without gaps
        press_request = 1'b1;
        send_calm     = 1'b1;
        pkt_bytes.delete();
        add_noise(40);
        pkt_disable_at = -1;
        pkt_enable_at  = -1;
        send_packet();

        // random packets: every kind once in turn, then mostly headers
        n_rand = 0;
        pkt_no = 0;
        while (n_rand < RANDOM_ITEMS) begin
            if (pkt_no < int'(PK_COUNT))
                kind = t_pkt_kind'(pkt_no);
            else if ($urandom_range(0, 4) == 0)
                kind = PK_NOISE;
            else
                kind = t_pkt_kind'($urandom_range(1, int'(PK_COUNT) - 1));
            build_packet(kind);
            send_calm = ($urandom_range(0, 3) == 0);
            if (kind == PK_PASS) begin
                cfg_write(REG_UNMAPPED, $urandom);
                set_enable(1'b0);
            end
            send_packet();
            if (!cfg_enable)
                set_enable(1'b1);
            n_rand += pkt_bytes.size();
            pkt_no++;
        end

        settle();
        if (mismatches == 0 && awaited_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/aegs_pkg.sv
rtl/aegs_front.sv
rtl/aegs_queue.sv
rtl/aegs_back.sv
rtl/accept_encoding_gzip_stripper_unit.sv
rtl/aegs_checker.sv
verif/testbench.sv
